// File: rtl/bf3_pkg.sv
// Shared types and constants of the 3x3 wrap-around box filter.
package bf3_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOTAL_W     = ADDR_W + 1;
  localparam int DIM_W       = 8;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int CHAN_W      = 8;
  localparam int CHANNELS    = 4;
  localparam int WORD_W      = CHAN_W * CHANNELS;
  localparam int SUM_W       = 12;
  localparam int DIV_CNT_W   = $clog2(ADDR_W);

  // floor(s/9) as (s * ceil(2^16/9)) >> 16, exact for s up to 9*255
  localparam int RECIP9      = 7282;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  localparam logic [2:0] CHAN_RGBA = 3'd4;

  localparam logic [DIM_W-1:0] RESET_WIDTH    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] RESET_HEIGHT   = DIM_W'(MAX_HEIGHT);
  localparam logic [2:0]       RESET_CHANNELS = 3'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_READ  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_t;

endpackage

// File: rtl/bf3_frame_ram.sv
// Single-port frame memory, one word per pixel, registered read.
module bf3_frame_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [bf3_pkg::ADDR_W-1:0]   addr,
  input  logic [bf3_pkg::WORD_W-1:0]   wdata,
  output logic [bf3_pkg::WORD_W-1:0]   rdata
);

  logic [bf3_pkg::WORD_W-1:0] mem [bf3_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/bf3_pos_div.sv
// Restoring divider: raster position / width -> row and column.
module bf3_pos_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bf3_pkg::ADDR_W-1:0]   dividend,
  input  logic [bf3_pkg::DIM_W-1:0]    divisor,
  output logic                         done,
  output logic [bf3_pkg::ROW_W-1:0]    quotient,
  output logic [bf3_pkg::COL_W-1:0]    remainder
);

  logic                             running;
  logic [bf3_pkg::DIV_CNT_W-1:0]    cnt;
  logic [bf3_pkg::ADDR_W-1:0]       quo;
  logic [bf3_pkg::DIM_W-1:0]        rem;
  logic [bf3_pkg::DIM_W:0]          shifted;
  logic                             fits;

  assign shifted = {rem, quo[bf3_pkg::ADDR_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == bf3_pkg::DIV_CNT_W'(bf3_pkg::ADDR_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[bf3_pkg::ADDR_W-2:0], fits};
      rem <= fits ? bf3_pkg::DIM_W'(shifted - {1'b0, divisor})
                  : shifted[bf3_pkg::DIM_W-1:0];
    end
  end

  assign quotient  = quo[bf3_pkg::ROW_W-1:0];
  assign remainder = rem[bf3_pkg::COL_W-1:0];

endmodule

// File: rtl/bf3_accum.sv
// Per-channel neighborhood sums and their floor(/9) means.
module bf3_accum (
  input  logic                       clk,
  input  bf3_pkg::acc_ctrl_t         ctrl,
  input  logic [bf3_pkg::WORD_W-1:0] word,
  output bf3_pkg::pixel_t            mean
);

  logic [bf3_pkg::CHANNELS-1:0][bf3_pkg::SUM_W-1:0] sums;
  logic [bf3_pkg::CHANNELS-1:0][bf3_pkg::SUM_W+bf3_pkg::RECIP_W-1:0] prod;

  always_ff @(posedge clk) begin
    for (int c = 0; c < bf3_pkg::CHANNELS; c++) begin
      if (ctrl.clear) begin
        sums[c] <= '0;
      end else if (ctrl.add) begin
        sums[c] <= sums[c] + bf3_pkg::SUM_W'(word[c*bf3_pkg::CHAN_W +: bf3_pkg::CHAN_W]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < bf3_pkg::CHANNELS; c++) begin
      prod[c] = (bf3_pkg::SUM_W+bf3_pkg::RECIP_W)'(sums[c])
              * (bf3_pkg::SUM_W+bf3_pkg::RECIP_W)'(bf3_pkg::RECIP9);
      mean[c] = prod[c][bf3_pkg::RECIP_SHIFT +: bf3_pkg::CHAN_W];
    end
  end

endmodule

// File: rtl/box_filter_3x3_wraparound.sv
// Top level: 3x3 wrap-around mean filter over a stored RGB/RGBA frame.
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  -------------------------------------------
//  in       to block   in_valid / in_stall   req_type, in_red, in_green, in_blue, in_alpha
//  out      from block out_valid / out_stall out_red, out_green, out_blue, out_alpha,
//                                            out_last
//  cfg      to block   cfg_write             cfg_index, cfg_data
//
// Load transfer: one write into the single-port frame memory.
// Pull transfer: setup, nine neighbor reads through the one memory port, drain and result
//   put the pixel in the output register.
// After a width write the first pull adds a restoring divide (position -> row/col) unless it restarts at the origin.
// Synchronous active-high reset; frame memory content is not cleared.
// Loads continue while a result waits; a finished pull holds in ST_DONE until it is free.

module box_filter_3x3_wraparound (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_last
);

  localparam int AW = bf3_pkg::ADDR_W;
  localparam int TW = bf3_pkg::TOTAL_W;
  localparam int DW = bf3_pkg::DIM_W;
  localparam int CW = bf3_pkg::COL_W;
  localparam int RW = bf3_pkg::ROW_W;

  // configuration registers
  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  logic [2:0]    channel_count;

  bf3_pkg::state_t state;

  logic [DW-1:0] w_eff, h_eff;
  logic [TW-1:0] total;

  logic [AW-1:0] load_pos, load_addr;
  logic [AW-1:0] emit_pos;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic          rc_valid;   // row/col agree with emit_pos for the current width

  logic [AW-1:0] base [3];   // raster index of column 0 in the three rows
  logic [CW-1:0] cols [3];
  logic [AW-1:0] base_mid;
  logic [1:0]    ra, cb;
  logic          rd_pend;
  logic [AW-1:0] rd_addr;

  logic          in_xfer, out_free, last_px;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [bf3_pkg::WORD_W-1:0]  ram_rdata;

  logic          div_start, div_done;
  logic [RW-1:0] div_row;
  logic [CW-1:0] div_col;

  bf3_pkg::acc_ctrl_t acc_ctrl;
  bf3_pkg::pixel_t    mean;

  // clamp dimensions: 0 acts as 1, above maximum acts as maximum
  always_comb begin
    if (frame_width == '0)                   w_eff = DW'(1);
    else if (frame_width > DW'(bf3_pkg::MAX_WIDTH)) w_eff = DW'(bf3_pkg::MAX_WIDTH);
    else                                     w_eff = frame_width;
    if (frame_height == '0)                  h_eff = DW'(1);
    else if (frame_height > DW'(bf3_pkg::MAX_HEIGHT)) h_eff = DW'(bf3_pkg::MAX_HEIGHT);
    else                                     h_eff = frame_height;
  end

  assign total = TW'(w_eff) * TW'(h_eff);

  assign in_stall = (state != bf3_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_px  = (TW'(emit_pos) + TW'(1)) >= total;

  // load address restarts when a register change left it past the frame
  assign load_addr = (TW'(load_pos) >= total) ? '0 : load_pos;

  // neighbor rows and columns, with wrap on both axes
  assign base_mid = emit_pos - AW'(col);
  assign rd_addr  = base[ra] + AW'(cols[cb]);

  assign ram_we   = in_xfer && (req_type == bf3_pkg::REQ_LOAD);
  assign ram_addr = (state == bf3_pkg::ST_READ) ? rd_addr : load_addr;

  assign div_start = in_xfer && (req_type == bf3_pkg::REQ_PULL) && !rc_valid &&
                     (TW'(emit_pos) < total);

  assign acc_ctrl.clear = (state == bf3_pkg::ST_SETUP);
  assign acc_ctrl.add   = rd_pend;

  bf3_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_alpha, in_blue, in_green, in_red}),
    .rdata (ram_rdata)
  );

  bf3_pos_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (emit_pos),
    .divisor   (w_eff),
    .done      (div_done),
    .quotient  (div_row),
    .remainder (div_col)
  );

  bf3_accum u_acc (
    .clk  (clk),
    .ctrl (acc_ctrl),
    .word (ram_rdata),
    .mean (mean)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= bf3_pkg::RESET_WIDTH;
      frame_height  <= bf3_pkg::RESET_HEIGHT;
      channel_count <= bf3_pkg::RESET_CHANNELS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bf3_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        bf3_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        bf3_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // sequencer and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bf3_pkg::ST_IDLE;
      load_pos  <= '0;
      emit_pos  <= '0;
      row       <= '0;
      col       <= '0;
      rc_valid  <= 1'b1;
      ra        <= '0;
      cb        <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // read data of a READ cycle arrives in the next cycle
      rd_pend <= (state == bf3_pkg::ST_READ);

      if (state == bf3_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // row/col become known by restart at the origin or a finished divide;
      // a width write makes them stale
      if ((state == bf3_pkg::ST_DIV && div_done) ||
          (state == bf3_pkg::ST_IDLE && in_xfer && req_type == bf3_pkg::REQ_PULL &&
           TW'(emit_pos) >= total)) begin
        rc_valid <= 1'b1;
      end else if (cfg_write && cfg_index == bf3_pkg::REG_FRAME_WIDTH) begin
        rc_valid <= 1'b0;
      end

      unique case (state)
        bf3_pkg::ST_IDLE: begin
          if (in_xfer) begin
            if (req_type == bf3_pkg::REQ_LOAD) begin
              load_pos <= ((TW'(load_addr) + TW'(1)) >= total) ? '0 : load_addr + 1'b1;
            end else if (TW'(emit_pos) >= total) begin
              // position left past the frame: restart at the origin
              emit_pos <= '0;
              row      <= '0;
              col      <= '0;
              state    <= bf3_pkg::ST_SETUP;
            end else if (!rc_valid) begin
              state <= bf3_pkg::ST_DIV;
            end else begin
              state <= bf3_pkg::ST_SETUP;
            end
          end
        end
        bf3_pkg::ST_DIV: begin
          if (div_done) begin
            row      <= div_row;
            col      <= div_col;
            state    <= bf3_pkg::ST_SETUP;
          end
        end
        bf3_pkg::ST_SETUP: begin
          ra    <= '0;
          cb    <= '0;
          state <= bf3_pkg::ST_READ;
        end
        bf3_pkg::ST_READ: begin
          if (cb == 2'd2) begin
            cb <= '0;
            ra <= ra + 1'b1;
            if (ra == 2'd2) begin
              state <= bf3_pkg::ST_DRAIN;
            end
          end else begin
            cb <= cb + 1'b1;
          end
        end
        bf3_pkg::ST_DRAIN: begin
          state <= bf3_pkg::ST_DONE;
        end
        bf3_pkg::ST_DONE: begin
          if (out_free) begin
            state     <= bf3_pkg::ST_IDLE;
            if (last_px) begin
              emit_pos <= '0;
              row      <= '0;
              col      <= '0;
            end else begin
              emit_pos <= emit_pos + 1'b1;
              if ((DW'(col) + DW'(1)) >= w_eff) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
            end
          end
        end
        default: state <= bf3_pkg::ST_IDLE;
      endcase
    end
  end

  // neighbor bases and columns, captured once per pull
  always_ff @(posedge clk) begin
    if (state == bf3_pkg::ST_SETUP) begin
      base[1] <= base_mid;
      base[0] <= (row == '0) ? AW'(total - TW'(w_eff)) : base_mid - AW'(w_eff);
      base[2] <= ((DW'(row) + DW'(1)) >= h_eff) ? '0 : base_mid + AW'(w_eff);
      cols[1] <= col;
      cols[0] <= (col == '0) ? CW'(w_eff - DW'(1)) : col - 1'b1;
      cols[2] <= ((DW'(col) + DW'(1)) >= w_eff) ? '0 : col + 1'b1;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == bf3_pkg::ST_DONE && out_free) begin
      out_red   <= mean[0];
      out_green <= mean[1];
      out_blue  <= mean[2];
      out_alpha <= (channel_count == bf3_pkg::CHAN_RGBA) ? mean[3] : '0;
      out_last  <= last_px;
    end
  end

endmodule

// File: rtl/bf3_checker.sv
// Port-level checks of the box filter, bound to the top level.
module bf3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_last))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // a pull occupies the block
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type |=> in_stall)
    else $error("block ready right after a pull transfer");

  // a load leaves the block ready in the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> !in_stall)
    else $error("block busy after a load transfer");

  // a new result only comes out of a pull in progress
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a pull in progress");

endmodule

bind box_filter_3x3_wraparound bf3_checker u_bf3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_last  (out_last)
);
